// ===== src/sli_pkg.sv =====
// Shared types and codes for the sorted list insertion core.
package sli_pkg;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_SORTED = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADPOS  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_BADREAD = 2'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic [5:0]         position;
		logic signed [31:0] value;
	} sli_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         length;
		logic signed [31:0] read_value;
	} sli_rsp_t;

	// Operation broadcast to every cell while a command walks the chain.
	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] value;
	} sli_op_t;

	// Token and carried word handed from one cell to the next.
	typedef struct packed {
		logic        tok;
		logic        placed;
		logic [31:0] carry;
	} sli_link_t;

endpackage

// ===== src/sli_cell.sv =====
// One list cell: holds one entry and passes the walking token to its neighbor.
module sli_cell import sli_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int IDX   = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sli_op_t                          op,
	input  logic [$clog2(DEPTH + 1) - 1 : 0] tgt,
	input  logic [$clog2(DEPTH + 1) - 1 : 0] count,
	input  sli_link_t                        li,
	output sli_link_t                        lo
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW - 1 : 0] IDXC = CW'(IDX);

	logic [31:0] entry_q;
	logic        tok_q;
	logic        placed_q;
	logic [31:0] carry_q;
	sli_link_t   nxt;
	logic        at_tgt;
	logic        at_end;
	logic        below;
	logic        lt_entry;
	logic        le_entry;
	logic        sorted_hit;
	logic        hit;
	logic        wr;
	logic [31:0] wdata;

	always_comb begin
		at_tgt   = (IDXC == tgt);
		at_end   = (IDXC == count);
		below    = (IDXC < count);
		lt_entry = (op.value < $signed(entry_q));
		le_entry = (op.value <= $signed(entry_q));
		// The head entry is passed over when equal; later entries are not.
		if (IDX == 0) begin
			sorted_hit = lt_entry || at_end;
		end else begin
			sorted_hit = (le_entry && below) || at_end;
		end
		unique case (op.command)
			CMD_APPEND, CMD_INSERT, CMD_READ: hit = at_tgt;
			CMD_SORTED:                       hit = sorted_hit;
			default:                          hit = 1'b0;
		endcase
	end

	always_comb begin
		nxt   = li;
		wr    = 1'b0;
		wdata = li.carry;
		if (li.tok) begin
			if (op.command != CMD_READ) begin
				if (!li.placed && hit) begin
					wr          = 1'b1;
					wdata       = op.value;
					nxt.carry   = entry_q;
					nxt.placed  = 1'b1;
				end else if (li.placed && (IDXC <= count)) begin
					// Shift: take the neighbor's word and hand ours on.
					wr        = 1'b1;
					wdata     = li.carry;
					nxt.carry = entry_q;
				end
			end else if (hit) begin
				nxt.carry = entry_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= 1'b0;
			placed_q <= 1'b0;
		end else begin
			tok_q    <= nxt.tok;
			placed_q <= nxt.placed;
		end
	end

	always_ff @(posedge clk) begin
		carry_q <= nxt.carry;
		if (wr) begin
			entry_q <= wdata;
		end
	end

	assign lo.tok    = tok_q;
	assign lo.placed = placed_q;
	assign lo.carry  = carry_q;

endmodule

// ===== src/sorted_list_insert_core.sv =====
// Top level of the sorted list insertion core: command control and the cell chain.
//
// A list of up to DEPTH signed 32-bit entries and a length. A command is
// transferred on req at a rising edge where start is high and busy is low.
// Commands: append, insert at a 1-based position, insert in sorted order,
// and read the entry at a 0-based index. Every command gives one result on
// rsp, marked by done for exactly one cycle; the receiver cannot stall it.
// A command that fails its checks (bad position, full list, read beyond the
// length) leaves the list as it is and its result appears the cycle after
// the transfer, with busy staying low.
// A command that passes launches a token down the row of DEPTH cells, one
// cell per cycle; each cell inserts, shifts or reads as the token passes.
// The result strobes once the token has left the last cell and busy falls at
// the same edge, so no new command is taken while the token walks the row.
// Reset empties the list; entry contents are not cleared and are never read
// before they are written.
module sorted_list_insert_core import sli_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sli_req_t req,
	output logic     done,
	output sli_rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = ((CW > 6) ? CW : 6) + 1;
	localparam logic [CW - 1 : 0] FULL_CNT = CW'(DEPTH);

	typedef enum logic {
		IDLE,
		WALK
	} state_t;

	state_t            state_q;
	logic [CW - 1 : 0] count_q;
	logic [CW - 1 : 0] opcnt_q;
	logic [CW - 1 : 0] tgt_q;
	sli_op_t           op_q;
	logic              tok0_q;
	logic              done_q;
	sli_rsp_t          rsp_q;

	sli_link_t         link [DEPTH + 1];

	logic              accept;
	logic [MW - 1 : 0] cnt_ext;
	logic [MW - 1 : 0] pos_ext;
	logic [MW - 1 : 0] len_ext;
	logic              full;
	logic [1:0]        status;
	logic [CW - 1 : 0] tgt;
	logic [CW - 1 : 0] new_count;

	assign accept = start && (state_q == IDLE);
	assign busy   = (state_q == WALK);

	always_comb begin
		cnt_ext = MW'(count_q);
		pos_ext = MW'(req.position);
		full    = (count_q == FULL_CNT);
		status  = ST_OK;
		tgt     = '0;
		unique case (req.command)
			CMD_APPEND: begin
				tgt = count_q;
				if (full) begin
					status = ST_FULL;
				end
			end
			CMD_INSERT: begin
				tgt = CW'(pos_ext - MW'(1));
				if ((req.position == '0) || (pos_ext > cnt_ext + MW'(1))) begin
					status = ST_BADPOS;
				end else if (full) begin
					status = ST_FULL;
				end
			end
			CMD_SORTED: begin
				if (full) begin
					status = ST_FULL;
				end
			end
			CMD_READ: begin
				tgt = CW'(pos_ext);
				if (pos_ext >= cnt_ext) begin
					status = ST_BADREAD;
				end
			end
			default: status = ST_OK;
		endcase
		if ((status == ST_OK) && (req.command != CMD_READ)) begin
			new_count = count_q + CW'(1);
		end else begin
			new_count = count_q;
		end
		len_ext = MW'(new_count);
	end

	assign link[0].tok    = tok0_q;
	assign link[0].placed = 1'b0;
	assign link[0].carry  = '0;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		sli_cell #(
			.DEPTH(DEPTH),
			.IDX  (k)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.op    (op_q),
			.tgt   (tgt_q),
			.count (opcnt_q),
			.li    (link[k]),
			.lo    (link[k + 1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			tok0_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			tok0_q <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						count_q <= new_count;
						if (status == ST_OK) begin
							tok0_q  <= 1'b1;
							state_q <= WALK;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				WALK: begin
					if (link[DEPTH].tok) begin
						done_q  <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Operation and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q.command     <= req.command;
			op_q.value       <= req.value;
			tgt_q            <= tgt;
			opcnt_q          <= count_q;
			rsp_q.status     <= status;
			rsp_q.length     <= len_ext[5:0];
			rsp_q.read_value <= '0;
		end else if ((state_q == WALK) && link[DEPTH].tok && (op_q.command == CMD_READ)) begin
			rsp_q.read_value <= link[DEPTH].carry;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
